[src/ctst_pkg.sv]
// ----------------------------------------------------------------------------
// ctst_pkg: shared types and constants of the task scheduler table
// Operation codes, result status codes, the table entry layout and the
// result record passed between the sequencer and the output register.
// ----------------------------------------------------------------------------
package ctst_pkg;

    localparam int MAX_TASKS_DEF = 8;
    localparam int RESULTS_MAX   = 8;
    localparam int CNT_W         = $clog2(RESULTS_MAX + 1);

    localparam logic [9:0] TICK_STEP_RESET = 10'd1;

    typedef enum logic [1:0] {
        FUNC_TICK     = 2'd0,
        FUNC_ADD      = 2'd1,
        FUNC_DISPATCH = 2'd2,
        FUNC_DELETE   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_NO_TASK = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0]  tag;
        logic [15:0] delay;
        logic [15:0] period;
        logic [7:0]  pending;
    } entry_t;

    typedef struct packed {
        status_t     status;
        logic [2:0]  slot_out;
        logic [7:0]  run_tag;
        logic        run_valid;
        logic        last;
    } res_t;

endpackage

[src/ctst_mem.sv]
// ----------------------------------------------------------------------------
// ctst_mem: task table storage
// One write port and one read port; read data is registered, so it is
// available the cycle after the read is issued.
// ----------------------------------------------------------------------------
module ctst_mem
    import ctst_pkg::*;
#(
    parameter int DEPTH  = MAX_TASKS_DEF,
    parameter int ADDR_W = 3
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  entry_t            wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output entry_t            rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/ctst_out_reg.sv]
// ----------------------------------------------------------------------------
// ctst_out_reg: result output register
// Holds one result until the downstream side takes the transfer; a new
// result may be loaded in the same cycle as the held one leaves.
// ----------------------------------------------------------------------------
module ctst_out_reg
    import ctst_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t push_data,
    output logic free,
    input  logic out_ready,
    output logic out_valid,
    output res_t out_data
);

    logic valid_reg;
    res_t data_reg;

    assign free      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg <= push_data;
        end
    end

endmodule

[src/cooperative_task_scheduler_table_unit.sv]
// ----------------------------------------------------------------------------
// cooperative_task_scheduler_table_unit: time-triggered task table
// Task slots held in a single-port-write, registered-read memory and
// walked slot by slot for tick and dispatch operations.
// ----------------------------------------------------------------------------
// One operation is handled at a time. Add and delete go from the input to
// S_FINISH, which loads the result into the output register. Tick and
// dispatch walk the table through the one memory read port: S_READ skips
// an empty slot or reads an occupied one, S_MODIFY modifies and writes it
// back, then S_FINISH issues the final result. Dispatch gives one result
// per slot with pending runs, at most 8, and the last one carries last; a
// held result waits for out_ready and stalls the walk. The next input is
// taken once the final result is in the output register.
// ----------------------------------------------------------------------------
module cooperative_task_scheduler_table_unit
    import ctst_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [7:0]  task_tag,
    input  logic [15:0] first_delay,
    input  logic [15:0] period,
    input  logic [2:0]  slot,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [2:0]  slot_out,
    output logic [7:0]  run_tag,
    output logic        run_valid,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [9:0]  cfg_data
);

    localparam int SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int FREE_W = $clog2(MAX_TASKS + 1);
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(MAX_TASKS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_MODIFY,
        S_FINISH
    } state_t;

    state_t             state_reg, state_next;
    func_t              op_reg, op_next;
    logic [SLOT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    res_t               hold_reg, hold_next;
    logic               hold_valid_reg, hold_valid_next;
    logic [MAX_TASKS-1:0] valid_reg, valid_next;
    logic [FREE_W-1:0]  free_reg, free_next;
    logic [9:0]         step_reg;

    logic               mem_we;
    logic [SLOT_W-1:0]  mem_waddr;
    entry_t             mem_wdata;
    logic               mem_re;
    entry_t             mem_rdata;

    logic               push;
    res_t               push_data;
    logic               out_free;
    res_t               out_data;

    logic [SLOT_W-1:0]  del_idx;
    logic               del_hit;
    logic               table_full;

    assign in_ready   = (state_reg == S_IDLE);
    assign cfg_ready  = 1'b1;
    assign del_idx    = SLOT_W'(slot);
    assign del_hit    = (32'(slot) < 32'(MAX_TASKS)) && valid_reg[del_idx];
    assign table_full = (free_reg == FREE_W'(MAX_TASKS));

    ctst_mem #(
        .DEPTH  (MAX_TASKS),
        .ADDR_W (SLOT_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (idx_reg),
        .rdata (mem_rdata)
    );

    ctst_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .free      (out_free),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    assign status    = out_data.status;
    assign slot_out  = out_data.slot_out;
    assign run_tag   = out_data.run_tag;
    assign run_valid = out_data.run_valid;
    assign last      = out_data.last;

    always_comb
    begin
        entry_t      upd;
        logic [15:0] step16;
        logic        walk_done;

        state_next      = state_reg;
        op_next         = op_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        valid_next      = valid_reg;
        free_next       = free_reg;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = mem_rdata;
        mem_re          = 1'b0;
        push            = 1'b0;
        push_data       = hold_reg;
        upd             = mem_rdata;
        step16          = 16'(step_reg);
        walk_done       = (idx_reg == LAST_IDX);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next         = func_t'(func);
                    idx_next        = '0;
                    cnt_next        = '0;
                    hold_next       = '0;
                    hold_valid_next = 1'b0;
                    case (func)
                        FUNC_TICK, FUNC_DISPATCH:
                        begin
                            state_next = S_READ;
                        end
                        FUNC_ADD:
                        begin
                            state_next = S_FINISH;
                            if (table_full)
                            begin
                                hold_next.status = ST_FULL;
                            end
                            else
                            begin
                                mem_we                    = 1'b1;
                                mem_waddr                 = SLOT_W'(free_reg);
                                mem_wdata.tag             = task_tag;
                                mem_wdata.delay           = first_delay;
                                mem_wdata.period          = period;
                                mem_wdata.pending         = 8'd0;
                                valid_next[SLOT_W'(free_reg)] = 1'b1;
                                free_next                 = FREE_W'(free_reg + 1'b1);
                                hold_next.slot_out        = 3'(free_reg);
                            end
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                            if (del_hit)
                            begin
                                valid_next[del_idx] = 1'b0;
                                hold_next.slot_out  = slot;
                            end
                            else
                            begin
                                hold_next.status = ST_NO_TASK;
                            end
                        end
                    endcase
                end
            end

            S_READ:
            begin
                if (valid_reg[idx_reg])
                begin
                    mem_re     = 1'b1;
                    state_next = S_MODIFY;
                end
                else if (walk_done)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_MODIFY:
            begin
                if (op_reg == FUNC_TICK)
                begin
                    if (mem_rdata.delay == 16'd0)
                    begin
                        if (mem_rdata.pending != 8'hFF)
                        begin
                            upd.pending = mem_rdata.pending + 8'd1;
                        end
                        if (mem_rdata.period != 16'd0)
                        begin
                            upd.delay = mem_rdata.period;
                        end
                    end
                    else if (mem_rdata.delay > step16)
                    begin
                        upd.delay = mem_rdata.delay - step16;
                    end
                    else
                    begin
                        upd.delay = 16'd0;
                    end
                    mem_we     = 1'b1;
                    mem_wdata  = upd;
                    state_next = walk_done ? S_FINISH : S_READ;
                    if (!walk_done)
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else if (mem_rdata.pending == 8'd0)
                begin
                    state_next = walk_done ? S_FINISH : S_READ;
                    if (!walk_done)
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else if (!hold_valid_reg || out_free)
                begin
                    // The previously found run goes out now that a later one exists.
                    if (hold_valid_reg)
                    begin
                        push           = 1'b1;
                        push_data      = hold_reg;
                        push_data.last = 1'b0;
                    end
                    upd.pending = mem_rdata.pending - 8'd1;
                    mem_we      = 1'b1;
                    mem_wdata   = upd;
                    if (mem_rdata.period == 16'd0)
                    begin
                        valid_next[idx_reg] = 1'b0;
                    end
                    hold_next.status    = ST_OK;
                    hold_next.slot_out  = 3'(idx_reg);
                    hold_next.run_tag   = mem_rdata.tag;
                    hold_next.run_valid = 1'b1;
                    hold_next.last      = 1'b0;
                    hold_valid_next     = 1'b1;
                    cnt_next            = cnt_reg + 1'b1;
                    if (walk_done || (cnt_next == CNT_W'(RESULTS_MAX)))
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_READ;
                        idx_next   = idx_reg + 1'b1;
                    end
                end
            end

            S_FINISH:
            begin
                if (out_free)
                begin
                    push            = 1'b1;
                    push_data       = hold_reg;
                    push_data.last  = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            hold_valid_reg <= 1'b0;
            valid_reg      <= '0;
            free_reg       <= '0;
            step_reg       <= TICK_STEP_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            hold_valid_reg <= hold_valid_next;
            valid_reg      <= valid_next;
            free_reg       <= free_next;
            if (cfg_valid)
            begin
                step_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        idx_reg  <= idx_next;
        cnt_reg  <= cnt_next;
        hold_reg <= hold_next;
    end

`ifndef SYNTHESIS
    // Slots are claimed in order and never reused, so no slot at or past
    // the allocation counter can be occupied.
    a_valid_below_free: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg >> free_reg) == '0)
    else $error("occupied slot beyond allocation counter");

    a_free_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= FREE_W'(MAX_TASKS))
    else $error("allocation counter beyond table size");

    // A dispatch leaves no unsent run behind when the next input arrives.
    a_no_stale_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> !hold_valid_reg)
    else $error("held dispatch result lost at new input");

    a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (func == FUNC_TICK || func == FUNC_DISPATCH))
            |=> !in_ready)
    else $error("input taken while table walk in progress");
`endif

endmodule
